FILE: rtl/core/tbch_pkg.sv
// shared types and constants of the time-binned charge histogram
// used by tbch_ctrl, tbch_dp and time_binned_charge_histogram; no dependencies
package tbch_pkg;

  localparam int unsigned TimeW      = 32;
  localparam int unsigned ChargeW    = 32;
  localparam int unsigned ContentW   = 48;
  localparam int unsigned BinOutW    = 10;
  localparam int unsigned WidthW     = 16;
  localparam int unsigned CmdW       = 2;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned BinsDefault = 1024;

  localparam logic [TimeW-1:0]  StartReset = '0;
  localparam logic [WidthW-1:0] WidthReset = 16'd200;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START = 1'b0,
    CFG_WIDTH = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_ADDR,
    ST_READ,
    ST_UPDATE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic addr_load;
    logic mem_read;
    logic update;
    logic clr_init;
    logic clr_step;
    logic emit_clear;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;
    logic clr_last;
  } dp_stat_t;

endpackage

FILE: rtl/core/tbch_ctrl.sv
// sequencing state machine of the histogram: divide, read, update, clear sweep
// depends on tbch_pkg
module tbch_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               clear_req_i,
  input  tbch_pkg::dp_stat_t stat_i,
  output tbch_pkg::dp_cmd_t  cmd_o,
  output logic               busy_o
);

  tbch_pkg::state_e state_q, state_d;
  logic             report_q, report_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tbch_pkg::ST_CLEAR;
      report_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      report_q <= report_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    report_d = report_q;
    cmd_o    = '0;
    busy_o   = 1'b1;
    case (state_q)
      tbch_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          cmd_o.emit_clear = report_q;
          report_d         = 1'b0;
          state_d          = tbch_pkg::ST_IDLE;
        end
      end
      tbch_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          if (clear_req_i) begin
            cmd_o.clr_init = 1'b1;
            report_d       = 1'b1;
            state_d        = tbch_pkg::ST_CLEAR;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = tbch_pkg::ST_DIV;
          end
        end
      end
      tbch_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = tbch_pkg::ST_ADDR;
        end
      end
      tbch_pkg::ST_ADDR: begin
        cmd_o.addr_load = 1'b1;
        state_d         = tbch_pkg::ST_READ;
      end
      tbch_pkg::ST_READ: begin
        cmd_o.mem_read = 1'b1;
        state_d        = tbch_pkg::ST_UPDATE;
      end
      tbch_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = tbch_pkg::ST_IDLE;
      end
      default: begin
        state_d = tbch_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/tbch_dp.sv
// datapath of the histogram: config registers, serial divider, bin memory, result registers
// depends on tbch_pkg
module tbch_dp #(
  parameter int unsigned BINS = tbch_pkg::BinsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tbch_pkg::dp_cmd_t                 cmd_i,
  output tbch_pkg::dp_stat_t                stat_o,
  input  logic                              cfg_we_i,
  input  logic [tbch_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tbch_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic [tbch_pkg::CmdW-1:0]         command_i,
  input  logic signed [tbch_pkg::TimeW-1:0] hit_time_i,
  input  logic [tbch_pkg::ChargeW-1:0]      charge_i,
  output logic                              done_o,
  output logic [tbch_pkg::BinOutW-1:0]      bin_index_o,
  output logic [tbch_pkg::ContentW-1:0]     bin_content_o,
  output logic                              saturated_o
);

  localparam int unsigned IdxW  = $clog2(BINS);
  localparam int unsigned TW    = tbch_pkg::TimeW;
  localparam int unsigned WW    = tbch_pkg::WidthW;
  localparam int unsigned CW    = tbch_pkg::ContentW;
  localparam int unsigned StepW = $clog2(TW);
  localparam logic [TW-1:0]   LastBin  = TW'(BINS - 1);
  localparam logic [IdxW-1:0] LastAddr = IdxW'(BINS - 1);

  // configuration
  logic [TW-1:0] start_q;
  logic [WW-1:0] width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= tbch_pkg::StartReset;
      width_q <= tbch_pkg::WidthReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tbch_pkg::CFG_START: start_q <= cfg_wdata_i[TW-1:0];
        tbch_pkg::CFG_WIDTH: width_q <= cfg_wdata_i[WW-1:0];
        default: ;
      endcase
    end
  end

  // exact time difference, sign bit flags underflow
  logic [TW:0] diff;
  assign diff = {hit_time_i[TW-1], hit_time_i} - {start_q[TW-1], start_q};

  // restoring divider, one quotient bit per step
  logic [TW-1:0]    quot_q;
  logic [WW:0]      rem_q;
  logic             neg_q;
  logic             add_q;
  logic [tbch_pkg::ChargeW-1:0] charge_q;
  logic [StepW-1:0] step_q;
  logic [WW:0]      rem_sh;
  logic [WW+1:0]    trial;

  assign rem_sh = {rem_q[WW-1:0], quot_q[TW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, width_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.load) begin
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + 1'b1;
    end
  end

  assign stat_o.div_last = (step_q == StepW'(TW - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      quot_q   <= diff[TW-1:0];
      rem_q    <= '0;
      neg_q    <= diff[TW];
      add_q    <= (command_i == tbch_pkg::CMD_ADD);
      charge_q <= charge_i;
    end else if (cmd_i.div_step) begin
      if (!trial[WW+1]) begin
        rem_q  <= trial[WW:0];
        quot_q <= {quot_q[TW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        quot_q <= {quot_q[TW-2:0], 1'b0};
      end
    end
  end

  // clamp to the underflow and overflow bins
  logic [IdxW-1:0] addr_q;
  logic [IdxW-1:0] addr_d;

  always_comb begin
    if (neg_q) begin
      addr_d = '0;
    end else if (quot_q > LastBin) begin
      addr_d = LastAddr;
    end else begin
      addr_d = quot_q[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr_load) begin
      addr_q <= addr_d;
    end
  end

  // clear sweep address
  logic [IdxW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_init) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  assign stat_o.clr_last = (clr_addr_q == LastAddr);

  // bin memory, read-modify-write
  logic [CW-1:0] mem [BINS];
  logic [CW-1:0] rdata_q;
  logic [CW:0]   sum;
  logic [CW-1:0] new_val;
  logic          sat;

  assign sum     = {1'b0, rdata_q} + (CW + 1)'(charge_q);
  assign sat     = add_q & sum[CW];
  assign new_val = !add_q ? rdata_q : (sum[CW] ? '1 : sum[CW-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      mem[clr_addr_q] <= '0;
    end else if (cmd_i.update && add_q) begin
      mem[addr_q] <= new_val;
    end
    if (cmd_i.mem_read) begin
      rdata_q <= mem[addr_q];
    end
  end

  // result registers
  logic [IdxW+tbch_pkg::BinOutW-1:0] bin_ext;
  logic                              done_q;
  logic [tbch_pkg::BinOutW-1:0]      bin_q;
  logic [CW-1:0]                     content_q;
  logic                              sat_q;

  assign bin_ext = {{tbch_pkg::BinOutW{1'b0}}, addr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.update | cmd_i.emit_clear;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      bin_q     <= bin_ext[tbch_pkg::BinOutW-1:0];
      content_q <= new_val;
      sat_q     <= sat;
    end else if (cmd_i.emit_clear) begin
      bin_q     <= '0;
      content_q <= '0;
      sat_q     <= 1'b0;
    end
  end

  assign done_o        = done_q;
  assign bin_index_o   = bin_q;
  assign bin_content_o = content_q;
  assign saturated_o   = sat_q;

endmodule

FILE: rtl/core/time_binned_charge_histogram.sv
// top level of the time-binned charge histogram
// depends on tbch_pkg, tbch_ctrl and tbch_dp
//
// keeps BINS 48-bit charge accumulators over time bins. a request is taken at a
// clock edge with start_i high and busy_o low. an add or query request runs
// through these steps in order: the accept, the bit-serial divider (one
// quotient bit per cycle), a clamp, then a read and an update of the
// single-port bin memory; the result strobe done_o is registered from the
// update step, and busy_o stays high until it shows. a clear request sweeps
// the memory one bin per cycle, with its result strobe at the end of the
// sweep. after reset the same sweep runs with busy_o high and no result.
// each result is on the ports for exactly one cycle while done_o is high;
// the receiver cannot stall it, so it must capture it in that cycle.
// configuration writes are taken at any edge with cfg_we_i high and must only
// be done while busy_o is low and no result is pending
module time_binned_charge_histogram #(
  parameter int unsigned BINS = tbch_pkg::BinsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [tbch_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tbch_pkg::CfgDataW-1:0]     cfg_wdata_i,
  // request
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [tbch_pkg::CmdW-1:0]         command_i,
  input  logic signed [tbch_pkg::TimeW-1:0] hit_time_i,
  input  logic [tbch_pkg::ChargeW-1:0]      charge_i,
  // result
  output logic                              done_o,
  output logic [tbch_pkg::BinOutW-1:0]      bin_index_o,
  output logic [tbch_pkg::ContentW-1:0]     bin_content_o,
  output logic                              saturated_o
);

  tbch_pkg::dp_cmd_t  dp_cmd;
  tbch_pkg::dp_stat_t dp_stat;

  // high command bit selects clear, so code three clears as well
  logic clear_req;
  assign clear_req = command_i[1];

  tbch_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .clear_req_i (clear_req),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd),
    .busy_o      (busy_o)
  );

  tbch_dp #(
    .BINS (BINS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .command_i     (command_i),
    .hit_time_i    (hit_time_i),
    .charge_i      (charge_i),
    .done_o        (done_o),
    .bin_index_o   (bin_index_o),
    .bin_content_o (bin_content_o),
    .saturated_o   (saturated_o)
  );

  // an accepted request always occupies the block
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not make the block busy");

  // a clipped add leaves the bin at its ceiling
  a_sat_ceiling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && saturated_o) |-> (&bin_content_o))
    else $error("saturated result below the ceiling");

  // one strobe per request
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // the block is free again when its result shows
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while still busy");

endmodule
